FILE: hdl/pdsa_pkg.sv
// Shared types and constants for the proper divisor sum and abundance block.
package pdsa_pkg;

  localparam int unsigned SUM_W = 35;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_TEST = 5'b00010,
    S_DIV  = 5'b00100,
    S_ADD  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

endpackage

FILE: hdl/proper_divisor_sum_abundance.sv
// Proper divisor sum and abundance test by trial division with a bit-serial divider.
//
// The block takes one number per transfer and returns the sum of its proper
// divisors together with a flag that is set when the number is less than that
// sum. Trial divisors run from 2 while their square does not exceed the number,
// and each one goes through a shared restoring divider that produces one
// quotient bit per cycle. number_stall stays high while an item is in work and
// while its result waits for the previous one to leave. The finished result
// sits in an output register, so a new number is taken while the previous
// result is still waiting to be collected.
module proper_divisor_sum_abundance
  import pdsa_pkg::*;
#(
  parameter int unsigned NUMBER_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 number_valid,
  output logic                 number_stall,
  input  logic [31:0]          number,
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic [SUM_W-1:0]     divisor_sum,
  output logic                 is_abundant
);

  localparam int unsigned NB  = NUMBER_BITS;
  localparam int unsigned DW  = (NB + 1) / 2 + 1;
  localparam int unsigned SQW = 2 * DW;
  localparam int unsigned CW  = $clog2(NB);

  state_t              state;
  logic [NB-1:0]       n;
  logic [DW-1:0]       d;
  logic [SQW-1:0]      sq;
  logic [DW-1:0]       r;
  logic [NB-1:0]       q;
  logic [CW-1:0]       cnt;
  logic [SUM_W-1:0]    acc;

  logic [DW:0]         trial;
  logic                fits;
  logic [SQW-1:0]      n_sq;
  logic [SUM_W-1:0]    pair_sum;

  assign number_stall = (state != S_IDLE);
  assign n_sq         = {{(SQW-NB){1'b0}}, n};
  assign trial        = {r, q[NB-1]};
  assign fits         = (trial >= {1'b0, d});
  assign pair_sum     = {{(SUM_W-DW){1'b0}}, d} + {{(SUM_W-NB){1'b0}}, q};

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall && (state != S_DONE)) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (number_valid) begin
            n     <= number[NB-1:0];
            d     <= DW'(2);
            sq    <= SQW'(4);
            acc   <= SUM_W'(1);
            state <= S_TEST;
          end
        end
        S_TEST: begin
          if (sq > n_sq) begin
            state <= S_DONE;
          end else begin
            r     <= '0;
            q     <= n;
            cnt   <= CW'(NB - 1);
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (fits) begin
            r <= DW'(trial - {1'b0, d});
          end else begin
            r <= trial[DW-1:0];
          end
          q <= {q[NB-2:0], fits};
          if (cnt == '0) begin
            state <= S_ADD;
          end else begin
            cnt <= cnt - CW'(1);
          end
        end
        S_ADD: begin
          if (r == '0) begin
            if (sq == n_sq) begin
              acc <= acc + {{(SUM_W-DW){1'b0}}, d};
            end else begin
              acc <= acc + pair_sum;
            end
          end
          sq    <= sq + {{(SQW-DW-1){1'b0}}, d, 1'b1};
          d     <= d + DW'(1);
          state <= S_TEST;
        end
        S_DONE: begin
          if (!result_valid || !result_stall) begin
            divisor_sum  <= acc;
            is_abundant  <= ({{(SUM_W-NB){1'b0}}, n} < acc);
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: tb/tb_proper_divisor_sum_abundance.sv
`timescale 1ns / 1ps
// Self-checking testbench for the proper divisor sum and abundance block.
module tb_proper_divisor_sum_abundance
  import pdsa_pkg::*;
();

  localparam int unsigned NUMBER_BITS = 32;
  localparam int RANDOM_ITEMS = 80;
  localparam int DRAIN_CYCLES = 100;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             abundant;
  } aliquot_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             number_valid = 1'b0;
  logic             number_stall;
  logic [31:0]      number = '0;
  logic             result_valid;
  logic             result_stall = 1'b0;
  logic [SUM_W-1:0] divisor_sum;
  logic             is_abundant;

  logic [31:0] pending_numbers[$];
  aliquot_t    expected_sums[$];
  int          total_items = 0;
  int          accepted_items = 0;
  int          errors = 0;
  int          send_gap = 0;
  int          recv_gap = 0;
  bit          send_steady = 1'b0;
  bit          recv_steady = 1'b0;

  proper_divisor_sum_abundance #(
    .NUMBER_BITS(NUMBER_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .number_valid(number_valid),
    .number_stall(number_stall),
    .number(number),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .divisor_sum(divisor_sum),
    .is_abundant(is_abundant)
  );

  function automatic aliquot_t predict_aliquot(logic [31:0] raw);
    longint unsigned n;
    longint unsigned d;
    longint unsigned acc;
    aliquot_t r;
    n = raw & ((64'd1 << NUMBER_BITS) - 64'd1);
    acc = 1;
    for (d = 2; d * d <= n; d++) begin
      if (n % d == 0) begin
        if (d * d != n) acc += d + n / d;
        else acc += d;
      end
    end
    r.sum = acc[SUM_W-1:0];
    r.abundant = (n < r.sum);
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] pick_number();
    int r;
    int k;
    r = $urandom_range(0, 19);
    if (r < 3) begin
      k = $urandom_range(2, 255);
      return k * k;
    end
    if (r < 16) return $urandom_range(0, 4095);
    if (r < 19) return $urandom_range(0, 65535);
    return $urandom_range(0, 1048575);
  endfunction

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    logic        next_valid;
    logic [31:0] next_number;
    if (rst) begin
      number_valid <= 1'b0;
    end else begin
      next_valid = number_valid;
      next_number = number;
      if (number_valid && !number_stall) begin
        expected_sums.insert(expected_sums.size(), predict_aliquot(number));
        accepted_items++;
        next_valid = 1'b0;
        if ($urandom_range(0, 15) == 0) send_steady = !send_steady;
        send_gap = send_steady ? 0 : pick_gap();
      end
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_numbers.size() > 0) begin
          next_valid = 1'b1;
          next_number = pending_numbers.pop_front();
        end
      end
      number_valid <= next_valid;
      number <= next_number;
    end
  end

  always @(posedge clk) begin
    aliquot_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_sums.size() == 0) begin
          errors++;
          $display("%0t: unexpected transfer, expected none, actual sum %0d abundant %0b",
                   $time, divisor_sum, is_abundant);
        end else begin
          want = expected_sums.pop_front();
          if (divisor_sum !== want.sum) begin
            errors++;
            $display("%0t: divisor_sum mismatch, expected %0d, actual %0d",
                     $time, want.sum, divisor_sum);
          end
          if (is_abundant !== want.abundant) begin
            errors++;
            $display("%0t: is_abundant mismatch, expected %0b, actual %0b",
                     $time, want.abundant, is_abundant);
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        result_stall <= 1'b1;
      end else begin
        if ($urandom_range(0, 31) == 0) recv_steady = !recv_steady;
        if (!recv_steady && $urandom_range(0, 3) == 0) recv_gap = pick_gap();
        result_stall <= (recv_gap > 0);
      end
    end
  end

  initial begin
    logic [31:0] directed[$];
    int i;
    directed = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd6, 32'd12, 32'd18, 32'd25,
                 32'd28, 32'd36, 32'd97, 32'd496, 32'd945, 32'd4096, 32'hFFFFFFFF,
                 32'd5040, 32'd8128, 32'd65521, 32'd720720, 32'd1000000};
    foreach (directed[j]) pending_numbers.insert(pending_numbers.size(), directed[j]);
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      pending_numbers.insert(pending_numbers.size(), pick_number());
    end
    total_items = pending_numbers.size();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    while (accepted_items < total_items || expected_sums.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && expected_sums.size() == 0) begin
      $display("proper_divisor_sum_abundance regression: pass");
    end else begin
      $display("proper_divisor_sum_abundance regression: fail");
    end
    $finish;
  end

  initial begin
    #300_000_000;
    $display("proper_divisor_sum_abundance regression: fail");
    $finish;
  end

endmodule
